### src/gne_pkg.sv
`default_nettype none

package gne_pkg;

  localparam int NODE_COUNT      = 1024;
  localparam int VISITED_ENTRIES = 32;
  localparam int VIS_W           = $clog2(VISITED_ENTRIES);
  localparam int NB_W            = 11;

  localparam logic [NB_W-1:0] NB_EMPTY = 11'h7FF;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_MARK   = 2'd1;
  localparam logic [1:0] FUNC_EXPAND = 2'd2;

  localparam logic [2:0] STAT_ADDED   = 3'd0;
  localparam logic [2:0] STAT_VISITED = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_NONE    = 3'd3;
  localparam logic [2:0] STAT_DONE    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } gne_state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic mark;
    logic expand;
    logic walk;
  } gne_cmd_t;

  typedef struct packed {
    logic done;
  } gne_sts_t;

endpackage

`default_nettype wire

### src/gne_ctrl.sv
`default_nettype none

module gne_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       func,
  input  wire gne_pkg::gne_sts_t sts,
  output gne_pkg::gne_cmd_t     cmd,
  output logic                  busy
);

  gne_pkg::gne_state_t state;
  gne_pkg::gne_state_t state_next;

  always_comb begin
    cmd.accept = start && (state == gne_pkg::ST_IDLE);
    cmd.load   = cmd.accept && (func == gne_pkg::FUNC_LOAD);
    cmd.mark   = cmd.accept && (func == gne_pkg::FUNC_MARK);
    cmd.expand = cmd.accept && (func == gne_pkg::FUNC_EXPAND);
    cmd.walk   = (state == gne_pkg::ST_WALK);
    busy       = (state != gne_pkg::ST_IDLE);
  end

  always_comb begin
    state_next = state;
    case (state)
      gne_pkg::ST_IDLE: begin
        if (cmd.expand) begin
          state_next = gne_pkg::ST_WALK;
        end
      end
      gne_pkg::ST_WALK: begin
        if (sts.done) begin
          state_next = gne_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gne_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gne_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### src/gne_datapath.sv
`default_nettype none

module gne_datapath #(
  parameter int DEGREE = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gne_pkg::gne_cmd_t             cmd,
  output gne_pkg::gne_sts_t                  sts,
  input  wire logic [9:0]                    node,
  input  wire logic [1:0]                    slot,
  input  wire logic signed [gne_pkg::NB_W-1:0] neighbor,
  output logic                               strobe,
  output logic signed [gne_pkg::NB_W-1:0]    neighbor_id,
  output logic [2:0]                         status,
  output logic [2:0]                         candidate_count,
  output logic                               last
);

  localparam int MEM_DEPTH = gne_pkg::NODE_COUNT * DEGREE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int IDX_W     = $clog2(DEGREE + 1);
  localparam int CNT_W     = $clog2(DEGREE + 1);

  logic [gne_pkg::NB_W-1:0] mem [MEM_DEPTH];
  logic [gne_pkg::NB_W-1:0] rd_data;
  logic [gne_pkg::NB_W-1:0] wr_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        node_addr;
  logic                     rd_en;
  logic                     wr_en;

  logic [ADDR_W-1:0]          base;
  logic [IDX_W-1:0]           idx;
  logic [gne_pkg::VISITED_ENTRIES-1:0] visited;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           cnt_after;

  logic [gne_pkg::NB_W-1:0]   pend_id;
  logic [2:0]                 pend_status;
  logic [CNT_W-1:0]           pend_count;
  logic                       pend_valid;

  logic [gne_pkg::VIS_W-1:0]  hash;
  logic                       walk_end;
  logic [2:0]                 st_cur;

  assign node_addr = ADDR_W'(node) * ADDR_W'(DEGREE);
  assign wr_addr   = node_addr + ADDR_W'(slot);
  assign wr_en     = cmd.load && (int'(slot) < DEGREE);
  assign wr_data   = neighbor[gne_pkg::NB_W-1] ? gne_pkg::NB_EMPTY : neighbor;

  assign hash      = rd_data[gne_pkg::VIS_W-1:0];
  assign walk_end  = (int'(idx) == DEGREE) || rd_data[gne_pkg::NB_W-1];
  assign sts.done  = cmd.walk && walk_end;

  always_comb begin
    if (visited[hash]) begin
      st_cur = gne_pkg::STAT_VISITED;
    end else if (int'(cnt) < DEGREE) begin
      st_cur = gne_pkg::STAT_ADDED;
    end else begin
      st_cur = gne_pkg::STAT_FULL;
    end
    cnt_after = (st_cur == gne_pkg::STAT_ADDED) ? cnt + CNT_W'(1) : cnt;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = node_addr;
    if (cmd.expand) begin
      rd_en = 1'b1;
    end else if (cmd.walk && !walk_end && (int'(idx) + 1 < DEGREE)) begin
      rd_en   = 1'b1;
      rd_addr = base + ADDR_W'(idx) + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // A walk result is held back by one slot so that its last flag is known
  // before the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      visited    <= '0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      strobe <= 1'b0;
      if (cmd.load || cmd.mark) begin
        strobe          <= 1'b1;
        neighbor_id     <= gne_pkg::NB_EMPTY;
        status          <= gne_pkg::STAT_DONE;
        candidate_count <= 3'(cnt);
        last            <= 1'b1;
        if (cmd.mark) begin
          visited[node[gne_pkg::VIS_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.expand) begin
        idx        <= '0;
        pend_valid <= 1'b0;
        base       <= node_addr;
      end
      if (cmd.walk) begin
        if (walk_end) begin
          strobe     <= 1'b1;
          last       <= 1'b1;
          pend_valid <= 1'b0;
          if (pend_valid) begin
            neighbor_id     <= pend_id;
            status          <= pend_status;
            candidate_count <= 3'(pend_count);
          end else begin
            neighbor_id     <= gne_pkg::NB_EMPTY;
            status          <= gne_pkg::STAT_NONE;
            candidate_count <= 3'(cnt);
          end
        end else begin
          idx         <= idx + IDX_W'(1);
          pend_id     <= rd_data;
          pend_status <= st_cur;
          pend_count  <= cnt_after;
          pend_valid  <= 1'b1;
          if (pend_valid) begin
            strobe          <= 1'b1;
            last            <= 1'b0;
            neighbor_id     <= pend_id;
            status          <= pend_status;
            candidate_count <= 3'(pend_count);
          end
          if (st_cur == gne_pkg::STAT_ADDED) begin
            cnt           <= cnt_after;
            visited[hash] <= 1'b1;
          end
        end
      end
    end
  end

  a_walk_end_last: assert property (@(posedge clk) disable iff (rst)
    sts.done |=> (strobe && last))
    else $error("walk ended without a final transfer");

  a_loadmark_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.mark) |=> (strobe && last && (status == gne_pkg::STAT_DONE)))
    else $error("load or mark gave no completion transfer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cnt) <= DEGREE)
    else $error("candidate count above list depth");

  a_cnt_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt >= $past(cnt)))
    else $error("candidate count decreased without reset");

  a_added_new: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && !walk_end && (st_cur == gne_pkg::STAT_ADDED)) |=> visited[$past(hash)])
    else $error("added neighbour not marked visited");

endmodule

`default_nettype wire

### src/graph_neighbor_expander_unit.sv
`default_nettype none

// Neighbour expansion unit for a fixed-degree graph search.
// An item is taken on a rising edge with start high and busy low. A load
// writes one adjacency slot, a mark sets one visited bit, and an expand walks
// the slots of a node up to the first empty one, checking each neighbour
// against the visited table and appending new ones to the candidate list.
// Every result is shown for exactly one cycle with strobe high; last is high
// on the final result of an item. The receiver cannot stall the unit.
// Load and mark answer in the cycle after the transfer and keep busy low, so a
// new item may follow in the next cycle.
// Expand holds busy while it walks the k neighbours before the first empty
// slot (at most DEGREE), one slot at a time through the single read port of
// the adjacency memory, with one slot of look-ahead for the last flag; its
// results are registered and come out one slot behind the walk, and a node
// with no neighbours gives a single result with status NONE.
// Reset clears the visited table, the candidate count and the controller.
// The adjacency memory is not cleared; a slot must be loaded before it is
// expanded.

module graph_neighbor_expander_unit #(
  parameter int DEGREE = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       func,
  input  wire logic [9:0]                       node,
  input  wire logic [1:0]                       slot,
  input  wire logic signed [gne_pkg::NB_W-1:0]  neighbor,
  output logic                                  strobe,
  output logic signed [gne_pkg::NB_W-1:0]       neighbor_id,
  output logic [2:0]                            status,
  output logic [2:0]                            candidate_count,
  output logic                                  last
);

  gne_pkg::gne_cmd_t cmd;
  gne_pkg::gne_sts_t sts;

  gne_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  gne_datapath #(
    .DEGREE (DEGREE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .node            (node),
    .slot            (slot),
    .neighbor        (neighbor),
    .strobe          (strobe),
    .neighbor_id     (neighbor_id),
    .status          (status),
    .candidate_count (candidate_count),
    .last            (last)
  );

endmodule

`default_nettype wire
